@@ src/mpdf_pkg.sv @@
// shared types, constants and helpers for the motif pair distance finder
// no dependencies; used by every file under src

package mpdf_pkg;

    // read and motif limits
    localparam int READ_LEN  = 128;
    localparam int MAX_MOTIF = 16;

    // field widths
    localparam int POS_W     = 8;
    localparam int LEN_W     = 5;
    localparam int GAP_W     = 7;
    localparam int CNT_W     = 32;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;

    localparam logic [GAP_W-1:0] GAP_MAX   = '1;
    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MOTIF_ONE_LOW    = 3'd0,
        CFG_MOTIF_ONE_HIGH   = 3'd1,
        CFG_MOTIF_ONE_LENGTH = 3'd2,
        CFG_MOTIF_TWO_LOW    = 3'd3,
        CFG_MOTIF_TWO_HIGH   = 3'd4,
        CFG_MOTIF_TWO_LENGTH = 3'd5
    } cfg_idx_t;

    // input item
    typedef struct packed {
        logic [7:0] base;
        logic       last_in_read;
    } in_t;

    // result item
    typedef struct packed {
        logic             found;
        logic [GAP_W-1:0] gap;
        logic [CNT_W-1:0] reads_seen;
        logic [CNT_W-1:0] reads_matched;
    } out_t;

    // per-cell compare result
    typedef struct packed {
        logic eq_one;
        logic eq_two;
    } cell_hit_t;

    // one character's summary, handed from the window to the tracker
    typedef struct packed {
        logic             active;
        logic             last;
        logic [POS_W-1:0] count;
        logic [POS_W-1:0] start_two;
        logic             match_one;
        logic             match_two;
    } step_t;

    // length register to usable motif length
    function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] res;
        begin
            if (len == '0)
                res = LEN_W'(1);
            else if (len > LEN_W'(MAX_MOTIF))
                res = LEN_W'(MAX_MOTIF);
            else
                res = len;
            return res;
        end
    endfunction

    // motif character i from the low and high words
    function automatic logic [7:0] motif_char(input logic [CFG_W-1:0] lo,
                                              input logic [CFG_W-1:0] hi,
                                              input logic [3:0]       idx);
        logic [CFG_W-1:0] w;
        begin
            w = idx[3] ? hi : lo;
            return w[{idx[2:0], 3'b000} +: 8];
        end
    endfunction

endpackage

@@ src/mpdf_cell.sv @@
// one cell of the character window: holds one recent character and compares it
// against the expected characters of both motifs
// depends on mpdf_pkg

module mpdf_cell (
    input  logic                  clk,
    input  logic                  shift_en,
    input  logic [7:0]            char_in,
    input  logic [7:0]            exp_one,
    input  logic                  use_one,
    input  logic [7:0]            exp_two,
    input  logic                  use_two,
    output logic [7:0]            char_out,
    output mpdf_pkg::cell_hit_t   hit
);

    logic [7:0] char_reg;

    // window shift, character moves one cell older
    always_ff @(posedge clk)
    begin
        if (shift_en)
            char_reg <= char_in;
    end

    assign char_out = char_reg;

    // a cell beyond the motif length never blocks a match
    always_comb
    begin
        hit.eq_one = !use_one || (char_reg == exp_one);
        hit.eq_two = !use_two || (char_reg == exp_two);
    end

endmodule

@@ src/mpdf_track.sv @@
// per-read tracking of motif positions, read counters and the result register
// depends on mpdf_pkg

module mpdf_track (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step_fire,
    input  mpdf_pkg::step_t   step,
    output logic              busy,
    output logic              out_valid,
    input  logic              out_ready,
    output mpdf_pkg::out_t    out_data
);

    logic                         have_first_reg, have_first_next;
    logic [mpdf_pkg::POS_W-1:0]   first_end_reg, first_end_next;
    logic                         have_second_reg, have_second_next;
    logic [mpdf_pkg::POS_W-1:0]   second_start_reg, second_start_next;
    logic [mpdf_pkg::CNT_W-1:0]   seen_reg, seen_next;
    logic [mpdf_pkg::CNT_W-1:0]   matched_reg, matched_next;
    logic                         out_valid_reg;
    mpdf_pkg::out_t               out_reg, out_next;
    logic                         ok;
    logic [mpdf_pkg::POS_W-1:0]   diff;

    // motif bookkeeping and result for one character
    always_comb
    begin
        have_first_next   = have_first_reg;
        first_end_next    = first_end_reg;
        have_second_next  = have_second_reg;
        second_start_next = second_start_reg;
        seen_next         = seen_reg;
        matched_next      = matched_reg;
        out_next          = out_reg;
        ok                = 1'b0;
        diff              = '0;

        if (step.active && step.match_one)
        begin
            have_first_next   = 1'b1;
            first_end_next    = step.count;
            have_second_next  = 1'b0;
            second_start_next = '0;
        end
        if (step.active && step.match_two && have_first_next && !have_second_next
            && step.start_two >= first_end_next)
        begin
            have_second_next  = 1'b1;
            second_start_next = step.start_two;
        end

        if (step.last)
        begin
            ok = have_first_next && have_second_next
                 && (first_end_next < mpdf_pkg::POS_W'(mpdf_pkg::READ_LEN));
            diff = second_start_next - first_end_next;
            out_next.found = ok;
            if (!ok)
                out_next.gap = '0;
            else if (diff > {1'b0, mpdf_pkg::GAP_MAX})
                out_next.gap = mpdf_pkg::GAP_MAX;
            else
                out_next.gap = diff[mpdf_pkg::GAP_W-1:0];
            if (seen_reg != mpdf_pkg::COUNT_MAX)
                seen_next = seen_reg + 1'b1;
            if (ok && matched_reg != mpdf_pkg::COUNT_MAX)
                matched_next = matched_reg + 1'b1;
            out_next.reads_seen    = seen_next;
            out_next.reads_matched = matched_next;
            // next read starts clean
            have_first_next   = 1'b0;
            first_end_next    = '0;
            have_second_next  = 1'b0;
            second_start_next = '0;
        end
    end

    // tracking state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_first_reg   <= 1'b0;
            first_end_reg    <= '0;
            have_second_reg  <= 1'b0;
            second_start_reg <= '0;
            seen_reg         <= '0;
            matched_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (step_fire)
            begin
                have_first_reg   <= have_first_next;
                first_end_reg    <= first_end_next;
                have_second_reg  <= have_second_next;
                second_start_reg <= second_start_next;
                seen_reg         <= seen_next;
                matched_reg      <= matched_next;
            end
            if (step_fire && step.last)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (step_fire && step.last)
            out_reg <= out_next;
    end

    assign busy      = out_valid_reg && !out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

@@ src/motif_pair_distance_finder.sv @@
// top level of the motif pair distance finder: config registers, window of cells
// depends on mpdf_pkg, mpdf_cell, mpdf_track
//
// Usage
//   Input channel in_valid/in_ready/in_data carries one read character per
//   transfer; last_in_read marks the final character of a read. Output channel
//   out_valid/out_ready/out_data carries one result per read: found flag, gap,
//   and saturating counts of reads seen and reads matched.
//   Config port: cfg_write with cfg_index and cfg_data writes one register in
//   the cycle it is high; write only while no read is in flight.
// Timing
//   One character per cycle sustained while no second last character is held
//   in the compare stage. A character enters the 16-cell window at its
//   transfer, the cells compare it the next cycle and the tracker updates;
//   a read's last character passes the compare stage, then the result register.
// Stall
//   While a result waits, characters are still taken; only a second last
//   character is held in the compare stage until the waiting result transfers.
// Reset
//   rst_n clears read tracking, counters and valids; motif words reset to 0
//   and both lengths to 1.

module motif_pair_distance_finder (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  mpdf_pkg::in_t                     in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output mpdf_pkg::out_t                    out_data,
    input  logic                              cfg_write,
    input  logic [mpdf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mpdf_pkg::CFG_W-1:0]        cfg_data
);

    localparam int NCELL = mpdf_pkg::MAX_MOTIF;

    logic [mpdf_pkg::CFG_W-1:0]   m1_lo_reg, m1_hi_reg, m2_lo_reg, m2_hi_reg;
    logic [mpdf_pkg::LEN_W-1:0]   m1_len_reg, m2_len_reg;
    logic [mpdf_pkg::LEN_W-1:0]   len_one, len_two;
    logic [mpdf_pkg::POS_W-1:0]   pos_reg;
    logic                         s1_valid_reg, s1_active_reg, s1_last_reg;
    logic [mpdf_pkg::POS_W-1:0]   s1_count_reg;
    logic                         in_fire, pos_active, s1_hold, s1_fire, busy;
    logic [7:0]                   chars [NCELL];
    mpdf_pkg::cell_hit_t          hits [NCELL];
    logic [NCELL-1:0]             eq_one, eq_two;
    mpdf_pkg::step_t              step;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_lo_reg  <= '0;
            m1_hi_reg  <= '0;
            m1_len_reg <= mpdf_pkg::LEN_W'(1);
            m2_lo_reg  <= '0;
            m2_hi_reg  <= '0;
            m2_len_reg <= mpdf_pkg::LEN_W'(1);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                mpdf_pkg::CFG_MOTIF_ONE_LOW:    m1_lo_reg  <= cfg_data;
                mpdf_pkg::CFG_MOTIF_ONE_HIGH:   m1_hi_reg  <= cfg_data;
                mpdf_pkg::CFG_MOTIF_ONE_LENGTH: m1_len_reg <= cfg_data[mpdf_pkg::LEN_W-1:0];
                mpdf_pkg::CFG_MOTIF_TWO_LOW:    m2_lo_reg  <= cfg_data;
                mpdf_pkg::CFG_MOTIF_TWO_HIGH:   m2_hi_reg  <= cfg_data;
                mpdf_pkg::CFG_MOTIF_TWO_LENGTH: m2_len_reg <= cfg_data[mpdf_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign len_one = mpdf_pkg::eff_len(m1_len_reg);
    assign len_two = mpdf_pkg::eff_len(m2_len_reg);

    // handshake and compare-stage flow
    assign s1_hold    = s1_valid_reg && s1_last_reg && busy;
    assign in_ready   = !s1_hold;
    assign in_fire    = in_valid && in_ready;
    assign s1_fire    = s1_valid_reg && !s1_hold;
    assign pos_active = pos_reg < mpdf_pkg::POS_W'(mpdf_pkg::READ_LEN);

    // position within the current read, stops at the read limit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else if (in_fire)
        begin
            if (in_data.last_in_read)
                pos_reg <= '0;
            else if (pos_active)
                pos_reg <= pos_reg + 1'b1;
        end
    end

    // compare stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_active_reg <= 1'b0;
            s1_last_reg   <= 1'b0;
            s1_count_reg  <= '0;
        end
        else if (!s1_hold)
        begin
            s1_valid_reg  <= in_fire;
            s1_active_reg <= pos_active;
            s1_last_reg   <= in_data.last_in_read;
            s1_count_reg  <= pos_reg + 1'b1;
        end
    end

    // window of cells, newest character in cell 0
    for (genvar k = 0; k < NCELL; k++)
    begin : g_cell
        logic [mpdf_pkg::LEN_W-1:0] idx_one, idx_two;
        logic [7:0]                 char_in;

        assign idx_one = len_one - mpdf_pkg::LEN_W'(1) - mpdf_pkg::LEN_W'(k);
        assign idx_two = len_two - mpdf_pkg::LEN_W'(1) - mpdf_pkg::LEN_W'(k);

        if (k == 0)
        begin : g_head
            assign char_in = in_data.base;
        end
        else
        begin : g_body
            assign char_in = chars[k-1];
        end

        mpdf_cell u_cell (
            .clk      (clk),
            .shift_en (in_fire && pos_active),
            .char_in  (char_in),
            .exp_one  (mpdf_pkg::motif_char(m1_lo_reg, m1_hi_reg, idx_one[3:0])),
            .use_one  (mpdf_pkg::LEN_W'(k) < len_one),
            .exp_two  (mpdf_pkg::motif_char(m2_lo_reg, m2_hi_reg, idx_two[3:0])),
            .use_two  (mpdf_pkg::LEN_W'(k) < len_two),
            .char_out (chars[k]),
            .hit      (hits[k])
        );

        assign eq_one[k] = hits[k].eq_one;
        assign eq_two[k] = hits[k].eq_two;
    end

    // combine cell hits for the character in the compare stage
    always_comb
    begin
        step.active    = s1_active_reg;
        step.last      = s1_last_reg;
        step.count     = s1_count_reg;
        step.start_two = s1_count_reg - mpdf_pkg::POS_W'(len_two);
        step.match_one = (s1_count_reg >= mpdf_pkg::POS_W'(len_one)) && (&eq_one);
        step.match_two = (s1_count_reg >= mpdf_pkg::POS_W'(len_two)) && (&eq_two);
    end

    mpdf_track u_track (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_fire (s1_fire),
        .step      (step),
        .busy      (busy),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

@@ src/mpdf_checker.sv @@
// port-level checks for the motif pair distance finder, bound to the top level
// depends on mpdf_pkg and motif_pair_distance_finder

module mpdf_checker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            out_valid,
    input  logic            out_ready,
    input  mpdf_pkg::out_t  out_data
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("result payload changed while stalled");

    // a failed read reports no gap
    a_gap_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.found |-> out_data.gap == '0)
        else $error("nonzero gap on failed read");

    // matched reads never outnumber reads seen
    a_count_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.reads_matched <= out_data.reads_seen)
        else $error("matched count above seen count");

endmodule

bind motif_pair_distance_finder mpdf_checker u_mpdf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
